[design/lcdts_pkg.sv]
// ----------------------------------------------------------------------------
// lcdts_pkg
// Shared types and constants for the LCD line timing and status block.
// ----------------------------------------------------------------------------
package lcdts_pkg;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_DISPLAY_ENABLE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_COMPARE_LINE   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_IRQ_ENABLES    = 2'd2;
    localparam int unsigned CFG_DATA_W = 8;

    // Bit positions within irq_enables.
    localparam int unsigned IRQ_HBLANK      = 0;
    localparam int unsigned IRQ_VBLANK      = 1;
    localparam int unsigned IRQ_OAM         = 2;
    localparam int unsigned IRQ_COINCIDENCE = 3;

    // Counter saturation value while the display is off.
    localparam int unsigned DOT_W   = 16;
    localparam int unsigned DOT_MAX = 65535;

    typedef enum logic [1:0] {
        MODE_HBLANK   = 2'd0,
        MODE_VBLANK   = 2'd1,
        MODE_OAM      = 2'd2,
        MODE_TRANSFER = 2'd3
    } lcd_mode_t;

    // One result transaction.
    typedef struct packed {
        logic [7:0] line_number;
        lcd_mode_t  mode;
        logic       coincidence;
        logic       stat_request;
        logic       vblank_request;
        logic       draw_line_valid;
        logic [7:0] drawn_line;
        logic       in_vblank;
    } lcd_result_t;

    // Static configuration handed to the step logic.
    typedef struct packed {
        logic       display_enable;
        logic [7:0] compare_line;
        logic [3:0] irq_enables;
    } lcd_cfg_t;

endpackage

[design/lcdts_step.sv]
// ----------------------------------------------------------------------------
// lcdts_step
// Combinational next-state and result logic for one timing transaction.
// ----------------------------------------------------------------------------
module lcdts_step import lcdts_pkg::*; #(
    parameter int unsigned LINE_CYCLES   = 456,
    parameter int unsigned VISIBLE_LINES = 144,
    parameter int unsigned TOTAL_LINES   = 154,
    parameter int unsigned OAM_END       = 80,
    parameter int unsigned TRANSFER_END  = 172,
    parameter int unsigned MOD_W         = 9
) (
    input  lcd_cfg_t             cfg,
    input  logic [7:0]           elapsed_cycles,
    input  logic [DOT_W-1:0]     dot_cur,
    input  logic [MOD_W-1:0]     mod_cur,
    input  logic [7:0]           line_cur,
    output logic [DOT_W-1:0]     dot_nxt,
    output logic [MOD_W-1:0]     mod_nxt,
    output logic [7:0]           line_nxt,
    output lcd_result_t          result
);

    localparam int unsigned MSW = MOD_W + 2;
    localparam logic [MSW-1:0]   LINE_1X = MSW'(LINE_CYCLES);
    localparam logic [MSW-1:0]   LINE_2X = MSW'(2 * LINE_CYCLES);
    localparam logic [MOD_W-1:0] SAT_MOD = MOD_W'(DOT_MAX % LINE_CYCLES);

    always_comb begin
        logic [DOT_W:0]     dot_sum;
        logic               dot_sat;
        logic [DOT_W-1:0]   dot_a;
        logic [MSW-1:0]     mod_sum;
        logic [MSW-1:0]     mod_red;
        logic [MOD_W-1:0]   mod_a;
        logic [7:0]         line_b;
        logic               visible;

        // The counter and its residue move together; the residue is what the
        // counter becomes when a line ends, so no divider is needed.
        dot_sum = {1'b0, dot_cur} + (DOT_W+1)'(elapsed_cycles);
        dot_sat = dot_sum[DOT_W];
        dot_a   = dot_sat ? DOT_W'(DOT_MAX) : dot_sum[DOT_W-1:0];

        mod_sum = MSW'(mod_cur) + MSW'(elapsed_cycles);
        if (mod_sum >= LINE_2X) begin
            mod_red = mod_sum - LINE_2X;
        end else if (mod_sum >= LINE_1X) begin
            mod_red = mod_sum - LINE_1X;
        end else begin
            mod_red = mod_sum;
        end
        mod_a = dot_sat ? SAT_MOD : mod_red[MOD_W-1:0];

        dot_nxt  = dot_a;
        mod_nxt  = mod_a;
        line_nxt = line_cur;
        result   = '0;

        if (cfg.display_enable) begin
            if (dot_a > DOT_W'(LINE_CYCLES)) begin
                if (line_cur < 8'(VISIBLE_LINES)) begin
                    result.draw_line_valid = 1'b1;
                    result.drawn_line      = line_cur;
                end
                line_nxt = line_cur + 8'd1;
                dot_nxt  = DOT_W'(mod_a);
            end
            if (line_nxt >= 8'(TOTAL_LINES)) begin
                line_nxt = '0;
                dot_nxt  = '0;
                mod_nxt  = '0;
            end
        end

        line_b  = line_nxt;
        visible = line_b < 8'(VISIBLE_LINES);

        result.line_number = line_b;
        result.coincidence = (line_b == cfg.compare_line);
        result.stat_request = result.coincidence && cfg.irq_enables[IRQ_COINCIDENCE];
        result.mode = MODE_HBLANK;

        if (cfg.display_enable) begin
            if (visible) begin
                if (dot_nxt < DOT_W'(OAM_END)) begin
                    result.mode = MODE_OAM;
                    if (cfg.irq_enables[IRQ_OAM]) begin
                        result.stat_request = 1'b1;
                    end
                end else if (dot_nxt < DOT_W'(TRANSFER_END)) begin
                    result.mode = MODE_TRANSFER;
                end else begin
                    result.mode = MODE_HBLANK;
                    if (cfg.irq_enables[IRQ_HBLANK]) begin
                        result.stat_request = 1'b1;
                    end
                end
            end else begin
                result.mode      = MODE_VBLANK;
                result.in_vblank = 1'b1;
                result.vblank_request = (line_b == 8'(VISIBLE_LINES))
                                        && cfg.irq_enables[IRQ_VBLANK];
            end
        end
    end

endmodule

[design/lcd_line_timing_stat.sv]
// ----------------------------------------------------------------------------
// lcd_line_timing_stat
// A result is registered and appears on the m_ side in the cycle after its input is accepted.
// Throughput: one input per cycle unless a held result stalls s_ready; the step
// logic sits between s_ and the result register; state moves per accepted input.
// Reset: aresetn (synchronous, active low) clears the counters, the line, all
// configuration registers and the result valid flag; no clearing pass is needed.
// ----------------------------------------------------------------------------
module lcd_line_timing_stat import lcdts_pkg::*; #(
    parameter int unsigned LINE_CYCLES   = 456,
    parameter int unsigned VISIBLE_LINES = 144,
    parameter int unsigned TOTAL_LINES   = 154,
    parameter int unsigned OAM_END       = 80,
    parameter int unsigned TRANSFER_END  = 172
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    // Configuration write port.
    input  logic                   cfg_write_enable,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,

    // Input channel: elapsed machine cycles.
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [7:0]             s_elapsed_cycles,

    // Result channel.
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [7:0]             m_line_number,
    output logic [1:0]             m_mode,
    output logic                   m_coincidence,
    output logic                   m_stat_request,
    output logic                   m_vblank_request,
    output logic                   m_draw_line_valid,
    output logic [7:0]             m_drawn_line,
    output logic                   m_in_vblank
);

    // Width of the dot counter residue modulo the line length.
    localparam int unsigned MOD_W = $clog2(LINE_CYCLES);

    // Timing state. mod_reg always holds dot_reg modulo LINE_CYCLES, kept up
    // alongside the counter so that the end of a line never needs a divider,
    // even after the counter has sat saturated while the display was off.
    logic [DOT_W-1:0] dot_reg,  dot_next;
    logic [MOD_W-1:0] mod_reg,  mod_next;
    logic [7:0]       line_reg, line_next;

    // Configuration registers.
    lcd_cfg_t cfg_reg;

    // Result register and its valid flag.
    lcd_result_t res_reg, res_next;
    logic        m_valid_reg;

    logic s_accept;

    // A new transaction is taken whenever the result register is empty or is
    // being emptied in the same cycle, so the block runs at one per cycle.
    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    lcdts_step #(
        .LINE_CYCLES   (LINE_CYCLES),
        .VISIBLE_LINES (VISIBLE_LINES),
        .TOTAL_LINES   (TOTAL_LINES),
        .OAM_END       (OAM_END),
        .TRANSFER_END  (TRANSFER_END),
        .MOD_W         (MOD_W)
    ) u_step (
        .cfg            (cfg_reg),
        .elapsed_cycles (s_elapsed_cycles),
        .dot_cur        (dot_reg),
        .mod_cur        (mod_reg),
        .line_cur       (line_reg),
        .dot_nxt        (dot_next),
        .mod_nxt        (mod_next),
        .line_nxt       (line_next),
        .result         (res_next)
    );

    // Configuration writes. Indexes beyond the register list are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_write_enable) begin
            unique case (cfg_index)
                CFG_DISPLAY_ENABLE: cfg_reg.display_enable <= cfg_data[0];
                CFG_COMPARE_LINE:   cfg_reg.compare_line   <= cfg_data;
                CFG_IRQ_ENABLES:    cfg_reg.irq_enables    <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Timing state advances once per accepted transaction.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dot_reg  <= '0;
            mod_reg  <= '0;
            line_reg <= '0;
        end else if (s_accept) begin
            dot_reg  <= dot_next;
            mod_reg  <= mod_next;
            line_reg <= line_next;
        end
    end

    // Output register: the valid flag is control and is reset; the payload
    // is simply loaded on every accepted transaction.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            res_reg <= res_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_line_number     = res_reg.line_number;
    assign m_mode            = res_reg.mode;
    assign m_coincidence     = res_reg.coincidence;
    assign m_stat_request    = res_reg.stat_request;
    assign m_vblank_request  = res_reg.vblank_request;
    assign m_draw_line_valid = res_reg.draw_line_valid;
    assign m_drawn_line      = res_reg.drawn_line;
    assign m_in_vblank       = res_reg.in_vblank;

`ifndef NO_ASSERTIONS
    // The residue must stay below the line length. One extra bit keeps a
    // line length that is a power of two representable.
    a_mod_range: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, mod_reg} < (MOD_W+1)'(LINE_CYCLES))
        else $error("dot residue out of range");

    // The line number never reaches the frame total.
    a_line_range: assert property (@(posedge aclk) disable iff (!aresetn)
        line_reg < 8'(TOTAL_LINES))
        else $error("line number reached frame total");

    // An accepted transaction always leaves a result behind.
    a_accept_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> m_valid_reg)
        else $error("accepted transaction produced no result");

    // A drawn line is always a visible one.
    a_drawn_visible: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && res_reg.draw_line_valid) |->
        (res_reg.drawn_line < 8'(VISIBLE_LINES)))
        else $error("drawn line outside the visible area");

    // Vblank flag and vblank mode are reported together.
    a_vblank_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (res_reg.in_vblank == (res_reg.mode == MODE_VBLANK)))
        else $error("vblank flag disagrees with mode");
`endif

endmodule

[dv/lcd_line_timing_stat_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lcd_line_timing_stat_test
// Self-checking bench for the LCD line timing and status block. Elapsed-cycle
// transactions are offered with random gaps. A line timing predictor in this
// file works out the status expected for each accepted transaction. A result
// process, stalling at random, compares every result transaction with the
// oldest expected status, field by field.
// ----------------------------------------------------------------------------
module lcd_line_timing_stat_test import lcdts_pkg::*;;

    // Timing of the block under test; the instance is built with the same values.
    localparam int unsigned LINE_CYCLES   = 456;
    localparam int unsigned VISIBLE_LINES = 144;
    localparam int unsigned TOTAL_LINES   = 154;
    localparam int unsigned OAM_END       = 80;
    localparam int unsigned TRANSFER_END  = 172;

    // Index 3 of the register port decodes to nothing and must be ignored.
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

    // The slowest correct run stays well inside this limit, so it is generous.
    localparam int unsigned CYCLE_LIMIT = 500000;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_write_enable;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_valid;
    logic                   s_ready;
    logic [7:0]             s_elapsed_cycles;
    logic                   m_valid;
    logic                   m_ready;
    logic [7:0]             m_line_number;
    logic [1:0]             m_mode;
    logic                   m_coincidence;
    logic                   m_stat_request;
    logic                   m_vblank_request;
    logic                   m_draw_line_valid;
    logic [7:0]             m_drawn_line;
    logic                   m_in_vblank;

    // Predictor state: its own copy of the counters and of the registers.
    logic [DOT_W-1:0] model_dots;
    logic [7:0]       model_line;
    logic             model_enable;
    logic [7:0]       model_compare;
    logic [3:0]       model_irq;

    // Status expected for every transaction accepted but not yet returned.
    lcd_result_t expected_status[$];

    int unsigned mismatch_count  = 0;
    int unsigned cycle_count     = 0;
    int unsigned holdoff_request = 0;
    bit          gaps_enabled    = 1'b1;
    logic        rx_block;

    lcd_line_timing_stat #(
        .LINE_CYCLES  (LINE_CYCLES),
        .VISIBLE_LINES(VISIBLE_LINES),
        .TOTAL_LINES  (TOTAL_LINES),
        .OAM_END      (OAM_END),
        .TRANSFER_END (TRANSFER_END)
    ) u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_elapsed_cycles (s_elapsed_cycles),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_line_number    (m_line_number),
        .m_mode           (m_mode),
        .m_coincidence    (m_coincidence),
        .m_stat_request   (m_stat_request),
        .m_vblank_request (m_vblank_request),
        .m_draw_line_valid(m_draw_line_valid),
        .m_drawn_line     (m_drawn_line),
        .m_in_vblank      (m_in_vblank)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Advances the line timing by one transaction and returns the status that
    // the block should report for it.
    function automatic lcd_result_t step_line_timing(input logic [7:0] cycles);
        lcd_result_t st;
        int unsigned dots;
        st   = '0;
        dots = model_dots + cycles;
        // With the display off nothing wraps the counter, so it sticks at the top.
        if (dots > DOT_MAX)
            dots = DOT_MAX;
        if (model_enable) begin
            // Strictly past the line length ends the line; at most one per step.
            if (dots > LINE_CYCLES) begin
                if (model_line < VISIBLE_LINES) begin
                    st.draw_line_valid = 1'b1;
                    st.drawn_line      = model_line;
                end
                model_line = model_line + 8'd1;
                dots       = dots % LINE_CYCLES;
            end
            if (model_line >= TOTAL_LINES) begin
                dots       = 0;
                model_line = 8'd0;
            end
        end
        st.line_number  = model_line;
        st.coincidence  = (model_line == model_compare);
        st.stat_request = st.coincidence && model_irq[IRQ_COINCIDENCE];
        st.mode         = MODE_HBLANK;
        if (model_enable) begin
            if (model_line < VISIBLE_LINES) begin
                if (dots < OAM_END) begin
                    st.mode = MODE_OAM;
                    if (model_irq[IRQ_OAM])
                        st.stat_request = 1'b1;
                end else if (dots < TRANSFER_END) begin
                    st.mode = MODE_TRANSFER;
                end else begin
                    st.mode = MODE_HBLANK;
                    if (model_irq[IRQ_HBLANK])
                        st.stat_request = 1'b1;
                end
            end else begin
                // Vblank lines always read as mode 1.
                st.mode           = MODE_VBLANK;
                st.in_vblank      = 1'b1;
                st.vblank_request = (model_line == VISIBLE_LINES) && model_irq[IRQ_VBLANK];
            end
        end
        model_dots = dots[DOT_W-1:0];
        return st;
    endfunction

    // Idle cycles before an item or after a result. Roughly half the draws are
    // zero so that back-to-back transactions still occur with gaps switched on.
    function automatic int pick_gap();
        if (!gaps_enabled || $urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(0, 17);
    endfunction

    // Elapsed counts lean towards large values so that many frames get walked,
    // with some small steps to land on the mode boundaries.
    function automatic logic [7:0] pick_elapsed();
        case ($urandom_range(0, 19))
            0, 1, 2:  return 8'($urandom_range(0, 15));
            3, 4, 5:  return 8'($urandom_range(0, 255));
            default:  return 8'($urandom_range(150, 255));
        endcase
    endfunction

    // Compare lines favour the frame edges and values that are never reached.
    function automatic logic [7:0] pick_compare();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'(TOTAL_LINES - 1);
            2:       return 8'(VISIBLE_LINES);
            3:       return 8'd255;
            default: return 8'($urandom_range(0, TOTAL_LINES - 1));
        endcase
    endfunction

    // Offers one elapsed-cycle transaction and records its expected status
    // once it is accepted. Valid stays high across back-to-back items.
    task automatic offer_elapsed(input logic [7:0] cycles);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_elapsed_cycles <= cycles;
        do @(posedge aclk); while (s_ready !== 1'b1);
        expected_status.push_back(step_line_timing(cycles));
    endtask

    // Stops offering and waits until every expected status has come back.
    // Every transaction yields exactly one result, so an empty queue means
    // the block is idle.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_status.size() != 0);
    endtask

    // Register writes only happen with the block idle.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        wait_for_results();
        cfg_write_enable <= 1'b1;
        cfg_index        <= idx;
        cfg_data         <= data;
        @(posedge aclk);
        cfg_write_enable <= 1'b0;
        case (idx)
            CFG_DISPLAY_ENABLE: model_enable  = data[0];
            CFG_COMPARE_LINE:   model_compare = data;
            CFG_IRQ_ENABLES:    model_irq     = data[3:0];
            default: ;
        endcase
    endtask

    // Hand-picked walk through the opening states: the display off after
    // reset, masking of unused register bits, every mode boundary and the
    // exact line length, which must not end a line.
    task automatic test_directed();
        offer_elapsed(8'd0);                      // line 0 meets the reset compare line
        write_reg(CFG_IRQ_ENABLES, 8'hFF);        // upper bits are not stored
        write_reg(CFG_UNUSED_INDEX, 8'hFF);       // no register behind this index
        offer_elapsed(8'd255);                    // coincidence request with display off
        write_reg(CFG_COMPARE_LINE, 8'd255);
        offer_elapsed(8'd0);
        write_reg(CFG_DISPLAY_ENABLE, 8'hFE);     // bit 0 clear, so it stays off
        offer_elapsed(8'd1);
        write_reg(CFG_DISPLAY_ENABLE, 8'h01);
        write_reg(CFG_COMPARE_LINE, 8'd1);
        offer_elapsed(8'd0);                      // counter at 256: hblank
        offer_elapsed(8'd200);                    // exactly the line length
        offer_elapsed(8'd1);                      // one past: line 0 drawn, oam
        offer_elapsed(8'd78);                     // last oam dot
        offer_elapsed(8'd1);                      // first transfer dot
        offer_elapsed(8'd91);                     // last transfer dot
        offer_elapsed(8'd1);                      // first hblank dot
        write_reg(CFG_IRQ_ENABLES, 8'h00);
        offer_elapsed(8'd255);
        offer_elapsed(8'd255);                    // ends line 1 with a remainder
        write_reg(CFG_COMPARE_LINE, 8'd2);
        offer_elapsed(8'd0);
        write_reg(CFG_IRQ_ENABLES, 8'h08);
        offer_elapsed(8'd128);
    endtask

    // Long stretch with the display off: the counter must saturate and the
    // line must hold. The next test switches the display on from there.
    task automatic test_display_off_saturation();
        write_reg(CFG_DISPLAY_ENABLE, 8'h00);
        write_reg(CFG_COMPARE_LINE, pick_compare());
        write_reg(CFG_IRQ_ENABLES, 8'h0F);
        repeat (270)
            offer_elapsed(8'($urandom_range(240, 255)));
    endtask

    // Free-running frames under one setting, in bursts that each run either with
    // random gaps or with none at all, chosen at random per burst.
    task automatic test_frame_run(input int unsigned count);
        write_reg(CFG_DISPLAY_ENABLE, 8'h01);
        write_reg(CFG_COMPARE_LINE, pick_compare());
        write_reg(CFG_IRQ_ENABLES, 8'($urandom_range(0, 255)));
        for (int unsigned i = 0; i < count; i++) begin
            if (i % 50 == 0)
                gaps_enabled = ($urandom_range(0, 3) != 0);
            offer_elapsed(pick_elapsed());
        end
        gaps_enabled = 1'b1;
    endtask

    // The receiver holds off for a long stretch while items keep coming with
    // no gaps, so the block fills and must stall its input.
    task automatic test_receiver_holdoff();
        gaps_enabled    = 1'b0;
        holdoff_request = 300;
        repeat (60)
            offer_elapsed(pick_elapsed());
        gaps_enabled = 1'b1;
    endtask

    // Short segments, each under its own register setting; the first two pin
    // the interrupt enables to their extremes and the display is sometimes
    // switched off in mid frame.
    task automatic test_config_sweep();
        for (int unsigned seg = 0; seg < 8; seg++) begin
            case (seg)
                0:       write_reg(CFG_IRQ_ENABLES, 8'h00);
                1:       write_reg(CFG_IRQ_ENABLES, 8'h0F);
                default: write_reg(CFG_IRQ_ENABLES, 8'($urandom_range(0, 255)));
            endcase
            write_reg(CFG_COMPARE_LINE, pick_compare());
            write_reg(CFG_DISPLAY_ENABLE,
                      8'($urandom_range(0, 255)) | 8'($urandom_range(0, 4) != 0));
            repeat (40)
                offer_elapsed(pick_elapsed());
        end
    endtask

    // Lowers m_ready for the requested number of cycles, counted here.
    initial begin : rx_holdoff
        rx_block <= 1'b0;
        forever begin
            wait (holdoff_request != 0);
            @(posedge aclk);
            rx_block <= 1'b1;
            repeat (holdoff_request) @(posedge aclk);
            rx_block <= 1'b0;
            holdoff_request = 0;
        end
    end

    // Result side: accepts status transactions with random stalls and checks
    // each against the oldest expectation.
    initial begin : status_checker
        int          stall_left;
        lcd_result_t got;
        lcd_result_t want;
        stall_left = 0;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (m_valid === 1'b1 && m_ready === 1'b1) begin
                got.line_number     = m_line_number;
                got.mode            = lcd_mode_t'(m_mode);
                got.coincidence     = m_coincidence;
                got.stat_request    = m_stat_request;
                got.vblank_request  = m_vblank_request;
                got.draw_line_valid = m_draw_line_valid;
                got.drawn_line      = m_drawn_line;
                got.in_vblank       = m_in_vblank;
                if (expected_status.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("%0t: result transaction with nothing expected", $realtime);
                    mismatch_count++;
                end else begin
                    want = expected_status.pop_front();
                    if (got !== want) begin
                        if (mismatch_count < 10)
                            $display({"%0t: status mismatch line %0d/%0d mode %0d/%0d ",
                                      "coin %b/%b stat %b/%b vbl %b/%b draw %b/%b ",
                                      "drawn %0d/%0d invbl %b/%b (expected/actual)"},
                                     $realtime, want.line_number, got.line_number,
                                     want.mode, got.mode, want.coincidence,
                                     got.coincidence, want.stat_request, got.stat_request,
                                     want.vblank_request, got.vblank_request,
                                     want.draw_line_valid, got.draw_line_valid,
                                     want.drawn_line, got.drawn_line,
                                     want.in_vblank, got.in_vblank);
                        mismatch_count++;
                    end
                end
                stall_left = pick_gap();
            end else if (stall_left > 0) begin
                stall_left--;
            end
            m_ready <= !rx_block && stall_left == 0;
        end
    end

    // Main sequence: reset once, then each test in turn.
    initial begin : test_sequence
        aresetn          <= 1'b0;
        cfg_write_enable <= 1'b0;
        cfg_index        <= CFG_DISPLAY_ENABLE;
        cfg_data         <= '0;
        s_valid          <= 1'b0;
        s_elapsed_cycles <= '0;
        model_dots    = '0;
        model_line    = '0;
        model_enable  = 1'b0;
        model_compare = '0;
        model_irq     = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_display_off_saturation();
        test_frame_run(450);
        test_receiver_holdoff();
        test_config_sweep();
        test_frame_run(150);

        // Drain, then wait on so that anything stray can still show up.
        wait_for_results();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && expected_status.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
